// File: sv/magic_length_deframer_top_macros.svh
// Assertion macros shared by the deframer checker.
`ifndef MAGIC_LENGTH_DEFRAMER_TOP_MACROS_SVH
`define MAGIC_LENGTH_DEFRAMER_TOP_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define MLD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define MLD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/mld_pkg.sv
// ----------------------------------------------------------------------------
// mld_pkg
// Types and constants shared by the magic word length deframer modules.
// ----------------------------------------------------------------------------
package mld_pkg;

  localparam int unsigned CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_WORD    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_BODY_LEN = 1'd1;

  localparam logic [31:0] SYNC_WORD_RESET    = 32'hFEFE_FEFE;
  localparam logic [31:0] MAX_BODY_LEN_RESET = 32'd65535;

  // Index of the final length byte within the header.
  localparam logic [1:0] LEN_LAST_IDX = 2'd3;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BODY     = 2'd0,
    KIND_OVERSIZE = 2'd1,
    KIND_ZERO_LEN = 2'd2
  } kind_t;

  typedef struct packed {
    logic [31:0] sync_word;
    logic [31:0] max_body_len;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  body_byte;
    logic        last_of_frame;
    logic [31:0] frame_length;
  } result_t;

endpackage

// File: sv/magic_length_deframer_top.sv
// ----------------------------------------------------------------------------
// magic_length_deframer_top
// Splits a byte stream into sync-word, length-prefixed frames.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready, rx_byte) takes one byte per transaction.
// The block hunts for the sync word in a four-byte window, collects a 4-byte
// big-endian length, then forwards each body byte with last_of_frame set on
// the final one. A length over max_body_len or of zero gives one error result
// on the fourth length byte and returns to the hunt. Sync and header bytes
// give no result.
// Output channel (out_valid/out_ready) carries kind, body_byte,
// last_of_frame and frame_length. A result is registered in the output
// register, or in the skid stage on a stall; one byte is taken every cycle
// while in_ready is high, and the per-byte state update is combinational.
// A stalled receiver is absorbed by a one-entry skid stage: in_ready drops
// once the output register and the skid stage are both full.
// The configuration channel (cfg_valid/cfg_ready) is always ready; write it
// only while the block is idle. Synchronous reset restores the register
// defaults, empties the output and restarts the hunt.
// ----------------------------------------------------------------------------
module magic_length_deframer_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     kind,
  output logic [7:0]                     body_byte,
  output logic                           last_of_frame,
  output logic [31:0]                    frame_length,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mld_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  mld_pkg::cfg_t    cfg;
  mld_pkg::result_t res;
  mld_pkg::result_t out_data;
  logic             res_valid;
  logic             accept;

  assign accept = in_valid && in_ready;

  mld_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mld_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  mld_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign kind          = out_data.kind;
  assign body_byte     = out_data.body_byte;
  assign last_of_frame = out_data.last_of_frame;
  assign frame_length  = out_data.frame_length;

endmodule

// File: sv/mld_cfg_regs.sv
// ----------------------------------------------------------------------------
// mld_cfg_regs
// Configuration register file: sync word and maximum body length.
// ----------------------------------------------------------------------------
module mld_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mld_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output mld_pkg::cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_word    <= mld_pkg::SYNC_WORD_RESET;
      cfg.max_body_len <= mld_pkg::MAX_BODY_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mld_pkg::REG_SYNC_WORD:    cfg.sync_word    <= cfg_data;
        mld_pkg::REG_MAX_BODY_LEN: cfg.max_body_len <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// File: sv/mld_parser.sv
// ----------------------------------------------------------------------------
// mld_parser
// Frame state machine: sync hunt, length collection and body pass-through.
// ----------------------------------------------------------------------------
module mld_parser (
  input  logic             clk,
  input  logic             rst,
  input  mld_pkg::cfg_t    cfg,
  input  logic             accept,
  input  logic [7:0]       rx_byte,
  output logic             res_valid,
  output mld_pkg::result_t res
);

  mld_pkg::phase_t phase, phase_next;
  logic [31:0] sync_window, sync_window_next;
  logic [1:0]  header_count, header_count_next;
  logic [31:0] announced_length, announced_length_next;
  logic [31:0] body_count, body_count_next;

  logic [31:0] window_shift;
  logic [31:0] length_shift;
  logic [31:0] count_inc;
  logic        sync_hit;
  logic        len_final;
  logic        len_over;
  logic        len_zero;
  logic        body_last;

  assign window_shift = {rx_byte, sync_window[31:8]};
  assign length_shift = {announced_length[23:0], rx_byte};
  assign count_inc    = body_count + 32'd1;
  assign sync_hit     = (window_shift == cfg.sync_word);
  assign len_final    = (header_count == mld_pkg::LEN_LAST_IDX);
  assign len_over     = (length_shift > cfg.max_body_len);
  assign len_zero     = (length_shift == 32'd0);
  assign body_last    = (count_inc >= announced_length);

  // Next state.
  always_comb begin
    phase_next            = phase;
    sync_window_next      = sync_window;
    header_count_next     = header_count;
    announced_length_next = announced_length;
    body_count_next       = body_count;
    case (phase)
      mld_pkg::PH_HEADER: begin
        announced_length_next = length_shift;
        if (len_final) begin
          if (len_over || len_zero) begin
            phase_next        = mld_pkg::PH_HUNT;
            sync_window_next  = '0;
            header_count_next = '0;
          end else begin
            phase_next        = mld_pkg::PH_BODY;
            body_count_next   = '0;
            header_count_next = '0;
          end
        end else begin
          header_count_next = header_count + 2'd1;
        end
      end
      mld_pkg::PH_BODY: begin
        body_count_next = count_inc;
        if (body_last) begin
          phase_next        = mld_pkg::PH_HUNT;
          sync_window_next  = '0;
          header_count_next = '0;
        end
      end
      default: begin
        // The unused phase code behaves as the hunt.
        phase_next       = mld_pkg::PH_HUNT;
        sync_window_next = window_shift;
        if (sync_hit) begin
          phase_next            = mld_pkg::PH_HEADER;
          header_count_next     = '0;
          announced_length_next = '0;
        end
      end
    endcase
  end

  // Result of the byte being accepted.
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    case (phase)
      mld_pkg::PH_HEADER: begin
        res.frame_length = length_shift;
        if (len_final && len_over) begin
          res_valid = accept;
          res.kind  = mld_pkg::KIND_OVERSIZE;
        end else if (len_final && len_zero) begin
          res_valid = accept;
          res.kind  = mld_pkg::KIND_ZERO_LEN;
        end
      end
      mld_pkg::PH_BODY: begin
        res_valid         = accept;
        res.kind          = mld_pkg::KIND_BODY;
        res.body_byte     = rx_byte;
        res.last_of_frame = body_last;
        res.frame_length  = announced_length;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= mld_pkg::PH_HUNT;
      sync_window      <= '0;
      header_count     <= '0;
      announced_length <= '0;
      body_count       <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      sync_window      <= sync_window_next;
      header_count     <= header_count_next;
      announced_length <= announced_length_next;
      body_count       <= body_count_next;
    end
  end

endmodule

// File: sv/mld_out_buf.sv
// ----------------------------------------------------------------------------
// mld_out_buf
// Output register with a skid stage, so input ready comes from a flop.
// ----------------------------------------------------------------------------
module mld_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mld_pkg::result_t push_data,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output mld_pkg::result_t out_data
);

  logic             skid_valid;
  mld_pkg::result_t skid_data;
  logic             taken;

  assign space = !skid_valid;
  assign taken = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (taken) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (taken) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (taken) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !out_ready) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule

// File: sv/mld_checker.sv
// ----------------------------------------------------------------------------
// mld_checker
// Port-level checks on the deframer's result channel.
// ----------------------------------------------------------------------------
`include "magic_length_deframer_top_macros.svh"

module mld_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [7:0]  body_byte,
  input logic        last_of_frame,
  input logic [31:0] frame_length
);

  `MLD_ASSERT(a_out_hold,
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(body_byte)
      && $stable(last_of_frame) && $stable(frame_length),
    "result changed while stalled")
  `MLD_ASSERT(a_error_fields,
    out_valid && kind != mld_pkg::KIND_BODY |-> body_byte == 8'd0 && !last_of_frame,
    "error result carries body fields")
  `MLD_ASSERT(a_zero_len,
    out_valid && kind == mld_pkg::KIND_ZERO_LEN |-> frame_length == 32'd0,
    "zero-length error with nonzero length")
  `MLD_ASSERT(a_body_len,
    out_valid && kind == mld_pkg::KIND_BODY |-> frame_length != 32'd0,
    "body byte of a zero-length frame")
  `MLD_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid right after reset")

endmodule

bind magic_length_deframer_top mld_checker u_mld_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .kind          (kind),
  .body_byte     (body_byte),
  .last_of_frame (last_of_frame),
  .frame_length  (frame_length)
);

// File: test/magic_length_deframer_top_test.sv
// ----------------------------------------------------------------------------
// magic_length_deframer_top_test
// Self-checking testbench for the sync-word, length-prefixed byte deframer.
// ----------------------------------------------------------------------------
// A tracker follows the hunt, header and body states byte by byte and queues
// the body bytes and header errors that each accepted byte should produce.
// Every result taken from the output is compared field by field against the
// oldest queued entry. The stream opens with a few hand-built frames on the
// reset settings, then runs phases of random frames, noise and broken
// headers under changing sync words and length limits. Both channels idle
// and stall at random.
// ----------------------------------------------------------------------------
module magic_length_deframer_top_test;

  class frame_scoreboard;
    logic [31:0]      sync_word;
    logic [31:0]      max_len;
    mld_pkg::phase_t  phase;
    logic [31:0]      window;
    logic [1:0]       hdr_count;
    logic [31:0]      length;
    logic [31:0]      body_count;
    mld_pkg::result_t pending[$];
    int               errors;

    function new();
      sync_word  = mld_pkg::SYNC_WORD_RESET;
      max_len    = mld_pkg::MAX_BODY_LEN_RESET;
      phase      = mld_pkg::PH_HUNT;
      window     = '0;
      hdr_count  = '0;
      length     = '0;
      body_count = '0;
      errors     = 0;
    endfunction

    function void write_reg(input logic [mld_pkg::CFG_INDEX_W-1:0] idx,
                            input logic [31:0] data);
      if (idx == mld_pkg::REG_SYNC_WORD) sync_word = data;
      else if (idx == mld_pkg::REG_MAX_BODY_LEN) max_len = data;
    endfunction

    function void enter_hunt();
      phase     = mld_pkg::PH_HUNT;
      window    = '0;
      hdr_count = '0;
    endfunction

    function void push(input mld_pkg::kind_t k, input logic [7:0] b, input logic is_last);
      mld_pkg::result_t r;
      r.kind          = k;
      r.body_byte     = b;
      r.last_of_frame = is_last;
      r.frame_length  = length;
      pending.push_back(r);
    endfunction

    // Called once per accepted input transaction.
    function void note_rx_byte(input logic [7:0] b);
      logic is_last;
      case (phase)
        mld_pkg::PH_HEADER: begin
          length = {length[23:0], b};
          if (hdr_count >= mld_pkg::LEN_LAST_IDX) begin
            // The oversize test wins over the zero-length test.
            if (length > max_len) begin
              enter_hunt();
              push(mld_pkg::KIND_OVERSIZE, 8'h00, 1'b0);
            end else if (length == 32'd0) begin
              enter_hunt();
              push(mld_pkg::KIND_ZERO_LEN, 8'h00, 1'b0);
            end else begin
              phase      = mld_pkg::PH_BODY;
              body_count = '0;
              hdr_count  = '0;
            end
          end else begin
            hdr_count = hdr_count + 2'd1;
          end
        end
        mld_pkg::PH_BODY: begin
          body_count = body_count + 32'd1;
          is_last    = (body_count >= length);
          if (is_last) enter_hunt();
          push(mld_pkg::KIND_BODY, b, is_last);
        end
        default: begin
          // The oldest byte ends up least significant in the window.
          phase  = mld_pkg::PH_HUNT;
          window = {b, window[31:8]};
          if (window == sync_word) begin
            phase     = mld_pkg::PH_HEADER;
            hdr_count = '0;
            length    = '0;
          end
        end
      endcase
    endfunction

    task report(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_output(input logic [1:0] k, input logic [7:0] b, input logic is_last,
                      input logic [31:0] len);
      mld_pkg::result_t want;
      if (pending.size() == 0) begin
        report($sformatf("result kind %0d byte %h with no transaction pending", k, b));
        return;
      end
      want = pending.pop_front();
      if (k !== want.kind)
        report($sformatf("kind got %0d expected %0d", k, want.kind));
      if (b !== want.body_byte)
        report($sformatf("body_byte got %h expected %h", b, want.body_byte));
      if (is_last !== want.last_of_frame)
        report($sformatf("last_of_frame got %b expected %b", is_last, want.last_of_frame));
      if (len !== want.frame_length)
        report($sformatf("frame_length got %h expected %h", len, want.frame_length));
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            in_valid;
  logic                            in_ready;
  logic [7:0]                      rx_byte;
  logic                            out_valid;
  logic                            out_ready;
  logic [1:0]                      kind;
  logic [7:0]                      body_byte;
  logic                            last_of_frame;
  logic [31:0]                     frame_length;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [mld_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [31:0]                     cfg_data;

  frame_scoreboard sb = new();
  int unsigned     bytes_sent;
  logic            steady;

  magic_length_deframer_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .body_byte     (body_byte),
    .last_of_frame (last_of_frame),
    .frame_length  (frame_length),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [31:0] pick_length(input logic [31:0] m);
    int unsigned r;
    logic [31:0] cap;
    r   = $urandom_range(99, 0);
    cap = (m < 32'd24) ? m : 32'd24;
    if (r < 8) return 32'd0;
    if (r < 20 && m != 32'hFFFF_FFFF) begin
      if (r < 14) return m + 32'd1;
      return $urandom_range(32'hFFFF_FFFF, m + 32'd1);
    end
    if (r < 24) return $urandom_range((m < 32'd200) ? m : 32'd200, 1);
    return $urandom_range(cap, 1);
  endfunction

  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= value;
    do @(posedge clk); while (!in_ready);
    sb.note_rx_byte(value);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [31:0] sync, input logic [31:0] len);
    for (int i = 0; i < 4; i++) send_byte(sync[8*i +: 8]);
    for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
    if (len != 32'd0 && len <= sb.max_len)
      for (int unsigned n = 0; n < len; n++) send_byte(8'($urandom));
  endtask

  // A stray match or a cut header can leave a frame open; feed it to its end.
  task automatic close_open_frame();
    int unsigned n;
    n = 0;
    while (sb.phase != mld_pkg::PH_HUNT && n < 400) begin
      send_byte(8'($urandom));
      n++;
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    // Hunt and header bytes give no result, so allow the pipeline to settle.
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input logic [31:0] sync, input logic [31:0] max_len);
    cfg_valid <= 1'b1;
    cfg_index <= mld_pkg::REG_SYNC_WORD;
    cfg_data  <= sync;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(mld_pkg::REG_SYNC_WORD, sync);
    cfg_index <= mld_pkg::REG_MAX_BODY_LEN;
    cfg_data  <= max_len;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(mld_pkg::REG_MAX_BODY_LEN, max_len);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(input logic [31:0] sync, input logic [31:0] max_len,
                                  input int unsigned quota);
    int unsigned start;
    int unsigned r;
    int unsigned k;
    start = bytes_sent;
    while (bytes_sent - start < quota) begin
      steady = ($urandom_range(3, 0) == 0);
      r = $urandom_range(99, 0);
      if (r < 80) begin
        send_frame(sync, pick_length(max_len));
      end else if (r < 90) begin
        repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
      end else if (r < 95 || max_len > 32'd64) begin
        // Part of the sync word, then a byte that breaks it.
        k = $urandom_range(3, 1);
        for (int i = 0; i < k; i++) send_byte(sync[8*i +: 8]);
        send_byte(sync[8*k +: 8] ^ 8'($urandom_range(255, 1)));
      end else begin
        // Header cut short; the following bytes complete the length.
        for (int i = 0; i < 4; i++) send_byte(sync[8*i +: 8]);
        repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
      end
    end
    steady = 1'b0;
    close_open_frame();
    wait_for_results();
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_output(kind, body_byte, last_of_frame, frame_length);
  end

  initial begin
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      if ($urandom_range(7, 0) == 0) repeat ($urandom_range(300, 100)) @(posedge clk);
      else repeat ($urandom_range(20, 1)) @(posedge clk);
      k_stall: begin
        int unsigned stall;
        stall = pick_gap();
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin
    logic [31:0] sync;
    logic [31:0] max_len;
    rst        = 1'b1;
    in_valid   = 1'b0;
    rx_byte    = '0;
    out_ready  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    steady     = 1'b0;
    bytes_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: a one-byte body, a zero length, and one byte too long.
    send_frame(mld_pkg::SYNC_WORD_RESET, 32'd1);
    send_frame(mld_pkg::SYNC_WORD_RESET, 32'd0);
    send_frame(mld_pkg::SYNC_WORD_RESET, mld_pkg::MAX_BODY_LEN_RESET + 32'd1);
    wait_for_results();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          sync    = 32'h0000_0000;
          max_len = 32'd1;
        end
        1: begin
          sync    = 32'hFFFF_FFFF;
          max_len = 32'hFFFF_FFFF;
        end
        2: begin
          sync    = mld_pkg::SYNC_WORD_RESET;
          max_len = mld_pkg::MAX_BODY_LEN_RESET;
        end
        default: begin
          sync = $urandom;
          case ($urandom_range(3, 0))
            0: max_len = $urandom_range(8, 1);
            1: max_len = $urandom_range(300, 9);
            2: max_len = $urandom_range(65535, 301);
            default: max_len = $urandom_range(32'hFFFF_FFFF, 1);
          endcase
        end
      endcase
      write_config(sync, max_len);
      run_random_phase(sync, max_len, 275);
    end

    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/mld_pkg.sv
sv/mld_cfg_regs.sv
sv/mld_parser.sv
sv/mld_out_buf.sv
sv/magic_length_deframer_top.sv
sv/mld_checker.sv
test/magic_length_deframer_top_test.sv
